// File: rtl/core/mbsp_pkg.sv
package mbsp_pkg;

    // width of every dimension, count and size in tiles
    localparam int unsigned DW = 11;
    // width of the iteration counter of the divider
    localparam int unsigned DIV_CNT_W = $clog2(DW + 1);

    // limit register widths
    localparam int unsigned ACT_LIM_W = 11;
    localparam int unsigned REB_LIM_W = 11;
    localparam int unsigned OUT_LIM_W = 13;
    localparam int unsigned SUB_LIM_W = 7;
    localparam int unsigned CFG_DATA_W = 13;
    localparam int unsigned CFG_IDX_W = 2;

    // register indexes of the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_ACT_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REB_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SUB_LIMIT = 2'd3;

    // stream payload widths
    localparam int unsigned IN_DATA_W = 40;
    localparam int unsigned OUT_DATA_W = 56;

    // request to the shared divider
    typedef struct packed {
        logic          start;
        logic [DW-1:0] dividend;
        logic [DW-1:0] divisor;
    } div_req_t;

    // answer of the shared divider
    typedef struct packed {
        logic          done;
        logic [DW-1:0] quot;
        logic [DW-1:0] rem;
    } div_rsp_t;

endpackage

// File: rtl/core/mbsp_div.sv
module mbsp_div (
    input  logic               clk,
    input  logic               rst_n,
    input  mbsp_pkg::div_req_t req,
    output mbsp_pkg::div_rsp_t rsp
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [mbsp_pkg::DIV_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [mbsp_pkg::DW-1:0]           rem_reg, rem_next;
    logic [mbsp_pkg::DW-1:0]           quo_reg, quo_next;
    logic [mbsp_pkg::DW-1:0]           dsr_reg, dsr_next;
    logic [mbsp_pkg::DW:0]             shifted;
    logic [mbsp_pkg::DW+1:0]           diff;

    // one restoring step: shift in the next dividend bit and try a subtract
    assign shifted = {rem_reg, quo_reg[mbsp_pkg::DW-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = mbsp_pkg::DIV_CNT_W'(mbsp_pkg::DW);
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (diff[mbsp_pkg::DW+1])
            begin
                rem_next = shifted[mbsp_pkg::DW-1:0];
            end
            else
            begin
                rem_next = diff[mbsp_pkg::DW-1:0];
            end
            quo_next = {quo_reg[mbsp_pkg::DW-2:0], ~diff[mbsp_pkg::DW+1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == mbsp_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
    assign rsp.rem  = rem_reg;

`ifndef SYNTHESIS
    // a result comes only out of a running division
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider result without a running division");

    // a division is never started against a zero divisor
    a_no_zero_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> req.divisor != '0)
        else $error("divider started with zero divisor");

    // the remainder always stays below the divisor when reported
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> rem_reg < dsr_reg)
        else $error("divider remainder not below divisor");
`endif

endmodule

// File: rtl/core/matmul_block_size_planner.sv
// channel   | direction | transfer contents
// s_axis    | in        | tdata: rows_tiles, inner_tiles, cols_tiles (11 bits each)
// m_axis    | out       | tdata: row_blocks, inner_blocks, col_blocks, sub_height, sub_width
// cfg       | in        | cfg_index selects a limit register, cfg_data is its new value
//
// one shape at a time; s_axis_tready is high only while the sequencer is idle
// every divisor trial runs one division in the shared 11-bit restoring divider;
// with no search an item only passes the phase checks, and each trial divisor
// adds one division (a few thousand trials for large prime dimensions)
// a finished result waits in the output register while the next shape is taken
// rst_n clears control state and sets the limits to 25, 10, 60 and 8
module matmul_block_size_planner #(
    parameter int unsigned MAX_DIM_TILES = 1024
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // rows_tiles [10:0], inner_tiles [21:11], cols_tiles [32:22], zero fill
    input  logic [mbsp_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // row_blocks [10:0], inner_blocks [21:11], col_blocks [32:22],
    // sub_height [43:33], sub_width [54:44], zero fill
    output logic [mbsp_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mbsp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mbsp_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int unsigned DW = mbsp_pkg::DW;
    localparam int unsigned PW = 2 * DW;

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_P1K   = 4'd1;
    localparam logic [3:0] S_P1M   = 4'd2;
    localparam logic [3:0] S_P2    = 4'd3;
    localparam logic [3:0] S_P3M   = 4'd4;
    localparam logic [3:0] S_P3N   = 4'd5;
    localparam logic [3:0] S_P4I   = 4'd6;
    localparam logic [3:0] S_P4    = 4'd7;
    localparam logic [3:0] S_INC   = 4'd8;
    localparam logic [3:0] S_DIVGO = 4'd9;
    localparam logic [3:0] S_DIVW  = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    // which count a divisor search raises
    localparam logic [2:0] T_KB  = 3'd0;
    localparam logic [2:0] T_MB  = 3'd1;
    localparam logic [2:0] T_NB  = 3'd2;
    localparam logic [2:0] T_NSH = 3'd3;
    localparam logic [2:0] T_NSW = 3'd4;

    logic [3:0]    state_reg, state_next;
    logic [3:0]    ret_reg, ret_next;
    logic [2:0]    tgt_reg, tgt_next;
    logic          hnext_reg, hnext_next;
    logic          out_valid_reg, out_valid_next;

    logic [mbsp_pkg::ACT_LIM_W-1:0] act_lim_reg;
    logic [mbsp_pkg::REB_LIM_W-1:0] reb_lim_reg;
    logic [mbsp_pkg::OUT_LIM_W-1:0] out_lim_reg;
    logic [mbsp_pkg::SUB_LIM_W-1:0] sub_lim_reg;

    logic [DW-1:0] m_reg, m_next, k_reg, k_next, n_reg, n_next;
    logic [DW-1:0] mb_reg, mb_next, kb_reg, kb_next, nb_reg, nb_next;
    logic [DW-1:0] nsh_reg, nsh_next, nsw_reg, nsw_next;
    logic [DW-1:0] bh_reg, bh_next, bw_reg, bw_next, cw_reg, cw_next;
    logic [DW-1:0] sh_reg, sh_next, sw_reg, sw_next;
    logic [DW-1:0] dim_reg, dim_next, cnt_reg, cnt_next;
    logic [mbsp_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic [DW-1:0] mul_a, mul_b;
    logic [PW-1:0] prod, lim;
    logic          over;

    mbsp_pkg::div_req_t div_req;
    mbsp_pkg::div_rsp_t div_rsp;

    // clamp a dimension into 1 .. MAX_DIM_TILES
    function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] v);
        logic [DW-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = DW'(1);
        end
        else if (32'(v) > 32'(MAX_DIM_TILES))
        begin
            r = DW'(MAX_DIM_TILES);
        end
        return r;
    endfunction

    // shared multiplier and limit compare
    always_comb
    begin
        mul_a = sh_reg;
        mul_b = sw_reg;
        lim   = PW'(sub_lim_reg);
        unique case (state_reg)
            S_P1K, S_P1M:
            begin
                mul_a = bw_reg;
                mul_b = bh_reg;
                lim   = PW'(act_lim_reg);
            end
            S_P3M, S_P3N:
            begin
                mul_a = bh_reg;
                mul_b = cw_reg;
                lim   = PW'(out_lim_reg);
            end
            default:
            begin
                mul_a = sh_reg;
                mul_b = sw_reg;
                lim   = PW'(sub_lim_reg);
            end
        endcase
    end

    assign prod = PW'(mul_a) * PW'(mul_b);
    assign over = prod > lim;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        tgt_next       = tgt_reg;
        hnext_next     = hnext_reg;
        out_valid_next = out_valid_reg;
        m_next   = m_reg;   k_next   = k_reg;   n_next   = n_reg;
        mb_next  = mb_reg;  kb_next  = kb_reg;  nb_next  = nb_reg;
        nsh_next = nsh_reg; nsw_next = nsw_reg;
        bh_next  = bh_reg;  bw_next  = bw_reg;  cw_next  = cw_reg;
        sh_next  = sh_reg;  sw_next  = sw_reg;
        dim_next = dim_reg; cnt_next = cnt_reg;
        out_data_next = out_data_reg;
        div_req.start    = 1'b0;
        div_req.dividend = dim_reg;
        div_req.divisor  = cnt_reg;

        // output register empties on a transfer
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    m_next  = clamp_dim(s_axis_tdata[DW-1:0]);
                    k_next  = clamp_dim(s_axis_tdata[2*DW-1:DW]);
                    n_next  = clamp_dim(s_axis_tdata[3*DW-1:2*DW]);
                    bh_next = clamp_dim(s_axis_tdata[DW-1:0]);
                    bw_next = clamp_dim(s_axis_tdata[2*DW-1:DW]);
                    cw_next = clamp_dim(s_axis_tdata[3*DW-1:2*DW]);
                    mb_next = DW'(1);
                    kb_next = DW'(1);
                    nb_next = DW'(1);
                    state_next = S_P1K;
                end
            end
            // phase one: split K while the activation block is too big
            S_P1K:
            begin
                if (over && bw_reg != DW'(1) && kb_reg < k_reg)
                begin
                    dim_next = k_reg; cnt_next = kb_reg; tgt_next = T_KB;
                    ret_next = S_P1K; state_next = S_INC;
                end
                else
                begin
                    state_next = S_P1M;
                end
            end
            // phase one: then split M
            S_P1M:
            begin
                if (over && mb_reg < m_reg)
                begin
                    dim_next = m_reg; cnt_next = mb_reg; tgt_next = T_MB;
                    ret_next = S_P1M; state_next = S_INC;
                end
                else
                begin
                    state_next = S_P2;
                end
            end
            // phase two: reblock width
            S_P2:
            begin
                if (32'(cw_reg) > 32'(reb_lim_reg) && nb_reg < n_reg)
                begin
                    dim_next = n_reg; cnt_next = nb_reg; tgt_next = T_NB;
                    ret_next = S_P2; state_next = S_INC;
                end
                else
                begin
                    state_next = S_P3M;
                end
            end
            // phase three: output block, M first
            S_P3M:
            begin
                if (over && bh_reg != DW'(1) && mb_reg < m_reg)
                begin
                    dim_next = m_reg; cnt_next = mb_reg; tgt_next = T_MB;
                    ret_next = S_P3M; state_next = S_INC;
                end
                else
                begin
                    state_next = S_P3N;
                end
            end
            // phase three: then N
            S_P3N:
            begin
                if (over && nb_reg < n_reg)
                begin
                    dim_next = n_reg; cnt_next = nb_reg; tgt_next = T_NB;
                    ret_next = S_P3N; state_next = S_INC;
                end
                else
                begin
                    state_next = S_P4I;
                end
            end
            S_P4I:
            begin
                sh_next    = bh_reg;
                sw_next    = cw_reg;
                nsh_next   = DW'(1);
                nsw_next   = DW'(1);
                hnext_next = 1'b1;
                state_next = S_P4;
            end
            // phase four: alternate height and width of the subblock
            S_P4:
            begin
                if (over && (nsh_reg < bh_reg || nsw_reg < cw_reg))
                begin
                    hnext_next = ~hnext_reg;
                    if (hnext_reg)
                    begin
                        if (nsh_reg < bh_reg)
                        begin
                            dim_next = bh_reg; cnt_next = nsh_reg; tgt_next = T_NSH;
                            ret_next = S_P4; state_next = S_INC;
                        end
                    end
                    else if (nsw_reg < cw_reg)
                    begin
                        dim_next = cw_reg; cnt_next = nsw_reg; tgt_next = T_NSW;
                        ret_next = S_P4; state_next = S_INC;
                    end
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            // divisor search: next trial count
            S_INC:
            begin
                cnt_next   = cnt_reg + DW'(1);
                state_next = S_DIVGO;
            end
            S_DIVGO:
            begin
                div_req.start = 1'b1;
                state_next    = S_DIVW;
            end
            S_DIVW:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.rem == '0)
                    begin
                        unique case (tgt_reg)
                            T_KB:
                            begin
                                kb_next = cnt_reg; bw_next = div_rsp.quot;
                            end
                            T_MB:
                            begin
                                mb_next = cnt_reg; bh_next = div_rsp.quot;
                            end
                            T_NB:
                            begin
                                nb_next = cnt_reg; cw_next = div_rsp.quot;
                            end
                            T_NSH:
                            begin
                                nsh_next = cnt_reg; sh_next = div_rsp.quot;
                            end
                            default:
                            begin
                                nsw_next = cnt_reg; sw_next = div_rsp.quot;
                            end
                        endcase
                        state_next = ret_reg;
                    end
                    else
                    begin
                        state_next = S_INC;
                    end
                end
            end
            // hand the result to the output register once it is free
            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_data_next  = {1'b0, sw_reg, sh_reg, nb_reg, kb_reg, mb_reg};
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    mbsp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // control state and limit registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            tgt_reg       <= T_KB;
            hnext_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
            act_lim_reg   <= mbsp_pkg::ACT_LIM_W'(25);
            reb_lim_reg   <= mbsp_pkg::REB_LIM_W'(10);
            out_lim_reg   <= mbsp_pkg::OUT_LIM_W'(60);
            sub_lim_reg   <= mbsp_pkg::SUB_LIM_W'(8);
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            tgt_reg       <= tgt_next;
            hnext_reg     <= hnext_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    mbsp_pkg::REG_ACT_LIMIT:
                        act_lim_reg <= cfg_data[mbsp_pkg::ACT_LIM_W-1:0];
                    mbsp_pkg::REG_REB_LIMIT:
                        reb_lim_reg <= cfg_data[mbsp_pkg::REB_LIM_W-1:0];
                    mbsp_pkg::REG_OUT_LIMIT:
                        out_lim_reg <= cfg_data[mbsp_pkg::OUT_LIM_W-1:0];
                    default:
                        sub_lim_reg <= cfg_data[mbsp_pkg::SUB_LIM_W-1:0];
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        m_reg   <= m_next;   k_reg   <= k_next;   n_reg   <= n_next;
        mb_reg  <= mb_next;  kb_reg  <= kb_next;  nb_reg  <= nb_next;
        nsh_reg <= nsh_next; nsw_reg <= nsw_next;
        bh_reg  <= bh_next;  bw_reg  <= bw_next;  cw_reg  <= cw_next;
        sh_reg  <= sh_next;  sw_reg  <= sw_next;
        dim_reg <= dim_next; cnt_reg <= cnt_next;
        out_data_reg <= out_data_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign cfg_ready     = 1'b1;

`ifndef SYNTHESIS
    // block counts never pass their dimensions while a shape is worked on
    a_counts_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE && state_reg != S_P1K) |->
            (kb_reg <= k_reg && mb_reg <= m_reg && nb_reg <= n_reg))
        else $error("block count beyond its dimension");

    // a divisor search starts only below its dimension
    a_search_below_dim: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_INC |-> cnt_reg < dim_reg)
        else $error("divisor search started at its dimension");

    // the result register is loaded only from the final state
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result loaded outside the final state");

    // an accepted divider result is always exact for a stored count
    a_exact_store: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIVW && div_rsp.done && div_rsp.rem == '0) |=>
            state_reg == $past(ret_reg))
        else $error("search did not return after an exact divisor");
`endif

endmodule

// File: test/matmul_block_size_planner_tb.sv
module matmul_block_size_planner_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DW = mbsp_pkg::DW;
    localparam int unsigned MAX_TILES = 1024;
    // long enough for every shape to take its slowest search, several times over
    localparam int unsigned CYCLE_LIMIT = 50_000_000;

    typedef struct {
        bit [DW-1:0] rows;
        bit [DW-1:0] inner;
        bit [DW-1:0] cols;
    } shape_t;

    typedef struct {
        bit [DW-1:0] row_blocks;
        bit [DW-1:0] inner_blocks;
        bit [DW-1:0] col_blocks;
        bit [DW-1:0] sub_height;
        bit [DW-1:0] sub_width;
    } plan_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic [mbsp_pkg::IN_DATA_W-1:0]     s_axis_tdata = '0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    logic [mbsp_pkg::OUT_DATA_W-1:0]    m_axis_tdata;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [mbsp_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [mbsp_pkg::CFG_DATA_W-1:0]    cfg_data = '0;

    // limits as the planner should hold them
    int unsigned act_limit;
    int unsigned reb_limit;
    int unsigned out_limit;
    int unsigned sub_limit;

    plan_t       pending_plans[$];
    int unsigned fail_count = 0;
    int unsigned shapes_sent = 0;
    int unsigned plans_checked = 0;
    int unsigned limit_writes = 0;
    int unsigned cycle_count = 0;
    int unsigned burst_left = 0;
    bit          sender_gaps = 1'b1;
    bit          stalls_on = 1'b1;
    logic [4:0]  stall_step = '0;
    logic [31:0] stall_mask = '1;

    matmul_block_size_planner uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #4 clk = ~clk;

    // run guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver stalls follow a 32-bit mask, reloaded each time the step counter wraps
    always @(posedge clk)
    begin
        stall_step <= stall_step + 1'b1;
        if (stall_step == '0)
        begin
            if (!stalls_on)
                stall_mask <= '1;
            else
                case ($urandom_range(0, 2))
                    0: stall_mask <= '1;
                    1: stall_mask <= $urandom;
                    default: stall_mask <= $urandom & $urandom;
                endcase
        end
        m_axis_tready <= stall_mask[stall_step];
    end

    function automatic int unsigned clamp_tiles(bit [DW-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_TILES)
            return MAX_TILES;
        return 32'(v);
    endfunction

    // smallest divisor of dim above cnt, held once it reaches dim
    function automatic int unsigned next_count(int unsigned dim, int unsigned cnt);
        int unsigned c;
        c = cnt;
        if (c >= dim)
            return c;
        c++;
        while (dim % c != 0)
            c++;
        return c;
    endfunction

    function automatic plan_t plan_shape(shape_t s);
        int unsigned m, k, n;
        int unsigned mb, kb, nb;
        int unsigned bh, bw, cw;
        int unsigned sh, sw, nsh, nsw;
        bit          height_next;
        plan_t       p;
        m = clamp_tiles(s.rows);
        k = clamp_tiles(s.inner);
        n = clamp_tiles(s.cols);
        mb = 1;
        kb = 1;
        nb = 1;
        bh = m;
        bw = k;
        cw = n;
        nsh = 1;
        nsw = 1;
        height_next = 1'b1;

        // activation block: split K first, then M
        if (m * k > act_limit)
        begin
            while (bw * bh > act_limit && bw != 1 && kb < k)
            begin
                kb = next_count(k, kb);
                bw = k / kb;
            end
            while (bw * bh > act_limit && mb < m)
            begin
                mb = next_count(m, mb);
                bh = m / mb;
            end
        end

        // reblock width
        while (cw > reb_limit && nb < n)
        begin
            nb = next_count(n, nb);
            cw = n / nb;
        end

        // output block: split M, then N
        if (bh * cw > out_limit)
        begin
            while (bh * cw > out_limit && bh != 1 && mb < m)
            begin
                mb = next_count(m, mb);
                bh = m / mb;
            end
            while (bh * cw > out_limit && nb < n)
            begin
                nb = next_count(n, nb);
                cw = n / nb;
            end
        end

        // subblock: alternate height and width, height first
        sh = bh;
        sw = cw;
        while (sh * sw > sub_limit && (nsh < bh || nsw < cw))
        begin
            if (height_next)
            begin
                nsh = next_count(bh, nsh);
                sh = bh / nsh;
            end
            else
            begin
                nsw = next_count(cw, nsw);
                sw = cw / nsw;
            end
            height_next = !height_next;
        end

        p.row_blocks = DW'(mb);
        p.inner_blocks = DW'(kb);
        p.col_blocks = DW'(nb);
        p.sub_height = DW'(sh);
        p.sub_width = DW'(sw);
        return p;
    endfunction

    task automatic compare_field(string name, logic [DW-1:0] want, logic [DW-1:0] got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // check each result transfer against the oldest expected plan
    always @(posedge clk)
    begin
        plan_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_plans.size() == 0)
            begin
                $error("result transfer with no shape outstanding: %h", m_axis_tdata);
                fail_count++;
            end
            else
            begin
                want = pending_plans.pop_front();
                compare_field("row_blocks", want.row_blocks, m_axis_tdata[10:0]);
                compare_field("inner_blocks", want.inner_blocks, m_axis_tdata[21:11]);
                compare_field("col_blocks", want.col_blocks, m_axis_tdata[32:22]);
                compare_field("sub_height", want.sub_height, m_axis_tdata[43:33]);
                compare_field("sub_width", want.sub_width, m_axis_tdata[54:44]);
                plans_checked++;
            end
        end
    end

    function automatic shape_t mk_shape(int unsigned r, int unsigned i, int unsigned c);
        shape_t s;
        s.rows = DW'(r);
        s.inner = DW'(i);
        s.cols = DW'(c);
        return s;
    endfunction

    // mostly small dimensions, since large ones make the searches long
    function automatic int unsigned random_dim();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return $urandom_range(1, 12);
        if (pick < 86)
            return $urandom_range(13, 64);
        if (pick < 94)
            return $urandom_range(65, 256);
        if (pick < 97)
            return $urandom_range(257, 2047);
        case ($urandom_range(0, 2))
            0: return 0;
            1: return MAX_TILES;
            default: return 2047;
        endcase
    endfunction

    // one shape transfer; bursts of random length with gaps between them
    task automatic send_shape(shape_t s);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = sender_gaps ? $urandom_range(0, 8) : 0;
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 6);
        end
        s_axis_tdata <= {{(mbsp_pkg::IN_DATA_W - 3 * DW){1'b0}}, s.cols, s.inner, s.rows};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_plans.push_back(plan_shape(s));
        burst_left--;
        shapes_sent++;
    endtask

    task automatic end_burst();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
    endtask

    // every shape gives a result, so the block is idle once none is outstanding
    task automatic await_idle();
        while (pending_plans.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_limit(logic [mbsp_pkg::CFG_IDX_W-1:0] idx, int unsigned value);
        await_idle();
        cfg_index <= idx;
        cfg_data <= value[mbsp_pkg::CFG_DATA_W-1:0];
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            mbsp_pkg::REG_ACT_LIMIT: act_limit = value % (1 << mbsp_pkg::ACT_LIM_W);
            mbsp_pkg::REG_REB_LIMIT: reb_limit = value % (1 << mbsp_pkg::REB_LIM_W);
            mbsp_pkg::REG_OUT_LIMIT: out_limit = value % (1 << mbsp_pkg::OUT_LIM_W);
            default: sub_limit = value % (1 << mbsp_pkg::SUB_LIM_W);
        endcase
        cfg_valid <= 1'b0;
        limit_writes++;
    endtask

    task automatic write_all_limits(int unsigned act, int unsigned reb, int unsigned outl,
                                    int unsigned sub);
        write_limit(mbsp_pkg::REG_ACT_LIMIT, act);
        write_limit(mbsp_pkg::REG_REB_LIMIT, reb);
        write_limit(mbsp_pkg::REG_OUT_LIMIT, outl);
        write_limit(mbsp_pkg::REG_SUB_LIMIT, sub);
    endtask

    // reset limits: extremes, clamping, primes and limit boundaries
    task automatic test_directed_default();
        send_shape(mk_shape(1, 1, 1));
        send_shape(mk_shape(0, 0, 0));
        send_shape(mk_shape(2047, 2047, 2047));
        send_shape(mk_shape(1024, 1024, 1024));
        send_shape(mk_shape(1025, 1, 1));
        send_shape(mk_shape(1, 1021, 1));
        send_shape(mk_shape(1, 1, 1019));
        send_shape(mk_shape(5, 5, 1));
        send_shape(mk_shape(5, 6, 1));
        send_shape(mk_shape(1, 1, 10));
        send_shape(mk_shape(1, 1, 11));
        send_shape(mk_shape(6, 1, 10));
        send_shape(mk_shape(7, 13, 17));
        send_shape(mk_shape(12, 36, 48));
        send_shape(mk_shape(64, 64, 64));
        send_shape(mk_shape(2, 4, 8));
        send_shape(mk_shape(3, 9, 27));
        end_burst();
    endtask

    // zero limits, unit limits, largest limits and all-ones register values
    task automatic test_limit_extremes();
        write_all_limits(0, 0, 0, 0);
        send_shape(mk_shape(12, 12, 12));
        send_shape(mk_shape(7, 1, 30));
        send_shape(mk_shape(0, 16, 9));
        end_burst();
        write_all_limits(1, 1, 1, 1);
        send_shape(mk_shape(6, 10, 15));
        send_shape(mk_shape(1, 1, 1));
        end_burst();
        write_all_limits(1024, 1024, 4096, 64);
        send_shape(mk_shape(32, 32, 32));
        send_shape(mk_shape(1024, 1, 1024));
        end_burst();
        write_all_limits(8191, 8191, 8191, 8191);
        send_shape(mk_shape(40, 50, 60));
        send_shape(mk_shape(48, 1, 96));
        end_burst();
    endtask

    // random shapes over several random limit settings and idling patterns
    task automatic test_random_shapes();
        int unsigned act, reb, outl, sub;
        for (int round = 0; round < 7; round++)
        begin
            if (round == 0)
                write_all_limits(25, 10, 60, 8);
            else if ($urandom_range(0, 4) == 0)
                write_all_limits($urandom_range(0, 8191), $urandom_range(0, 8191),
                                 $urandom_range(0, 8191), $urandom_range(0, 8191));
            else
            begin
                act = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 120);
                reb = $urandom_range(0, 32);
                outl = $urandom_range(0, 400);
                sub = $urandom_range(0, 20);
                write_all_limits(act, reb, outl, sub);
            end
            sender_gaps = (round % 3 != 1);
            stalls_on = (round % 3 != 2);
            for (int i = 0; i < 16; i++)
                send_shape(mk_shape(random_dim(), random_dim(), random_dim()));
            end_burst();
        end
        sender_gaps = 1'b1;
        stalls_on = 1'b1;
    endtask

    initial
    begin
        act_limit = 25;
        reb_limit = 10;
        out_limit = 60;
        sub_limit = 8;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_default();
        test_limit_extremes();
        test_random_shapes();

        await_idle();
        repeat (50) @(posedge clk);

        $display("planned %0d shapes, %0d results checked, %0d limit register writes",
                 shapes_sent, plans_checked, limit_writes);
        $display("limits ranged from zero to all-ones, with sender gaps and receiver stalls");
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/mbsp_pkg.sv
rtl/core/mbsp_div.sv
rtl/core/matmul_block_size_planner.sv
test/matmul_block_size_planner_tb.sv
